// ===== rtl/core/gbts_pkg.sv =====
package gbts_pkg;

   localparam int OP_W    = 3;
   localparam int BYTE_W  = 8;
   localparam int FIELD_W = 11;
   localparam int STAT_W  = 2;

   localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE     = 3'd1;
   localparam logic [OP_W-1:0] OP_MOVE_LEFT  = 3'd2;
   localparam logic [OP_W-1:0] OP_MOVE_RIGHT = 3'd3;
   localparam logic [OP_W-1:0] OP_MOVE_TO    = 3'd4;
   localparam logic [OP_W-1:0] OP_READ       = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic load;
      logic prep;
      logic clamp;
      logic step;
      logic exec;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            count_zero;
   } dp_stat_type;

endpackage

// ===== rtl/core/gbts_req_if.sv =====
interface gbts_req_if;
   logic                          valid;
   logic                          ready;
   logic [gbts_pkg::OP_W-1:0]     opcode;
   logic [gbts_pkg::BYTE_W-1:0]   data_byte;
   logic [gbts_pkg::FIELD_W-1:0]  amount;
   logic [gbts_pkg::FIELD_W-1:0]  position;

   modport source (output valid, output opcode, output data_byte, output amount,
                   output position, input ready);
   modport sink (input valid, input opcode, input data_byte, input amount,
                 input position, output ready);
endinterface

// ===== rtl/core/gbts_rsp_if.sv =====
interface gbts_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gbts_pkg::STAT_W-1:0]   status;
   logic [gbts_pkg::FIELD_W-1:0]  cursor;
   logic [gbts_pkg::FIELD_W-1:0]  text_length;
   logic [gbts_pkg::FIELD_W-1:0]  moved;
   logic [gbts_pkg::BYTE_W-1:0]   read_byte;

   modport source (output valid, output status, output cursor, output text_length,
                   output moved, output read_byte, input ready);
   modport sink (input valid, input status, input cursor, input text_length,
                 input moved, input read_byte, output ready);
endinterface

// ===== rtl/core/gbts_ram.sv =====
module gbts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/gbts_ctrl.sv =====
module gbts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output gbts_pkg::dp_cmd_type    cmd,
   input  gbts_pkg::dp_stat_type   stat
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_CLAMP = 3'd2;
   localparam logic [2:0] S_MOVE  = 3'd3;
   localparam logic [2:0] S_EXEC  = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       is_move;

   assign is_move = (stat.opcode == gbts_pkg::OP_MOVE_LEFT) ||
                    (stat.opcode == gbts_pkg::OP_MOVE_RIGHT) ||
                    (stat.opcode == gbts_pkg::OP_MOVE_TO);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = is_move ? S_MOVE : S_EXEC;
         end
         S_MOVE: begin
            if (stat.count_zero) begin
               state_in = S_DRAIN;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            // hold the word until the output register is free
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/gbts_dp.sv =====
module gbts_dp #(
   parameter int CAPACITY = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gbts_pkg::dp_cmd_type             cmd,
   output gbts_pkg::dp_stat_type            stat,
   input  logic [gbts_pkg::OP_W-1:0]        req_opcode,
   input  logic [gbts_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic [gbts_pkg::FIELD_W-1:0]     req_amount,
   input  logic [gbts_pkg::FIELD_W-1:0]     req_position,
   output logic [gbts_pkg::STAT_W-1:0]      rsp_status,
   output logic [gbts_pkg::FIELD_W-1:0]     rsp_cursor,
   output logic [gbts_pkg::FIELD_W-1:0]     rsp_text_length,
   output logic [gbts_pkg::FIELD_W-1:0]     rsp_moved,
   output logic [gbts_pkg::BYTE_W-1:0]      rsp_read_byte
);

   localparam int PW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = (PW > gbts_pkg::FIELD_W) ? PW : gbts_pkg::FIELD_W;
   localparam int FW = gbts_pkg::FIELD_W;
   localparam int BW = gbts_pkg::BYTE_W;

   logic [gbts_pkg::OP_W-1:0] op_ff, op_in;
   logic [BW-1:0]             byte_ff, byte_in;
   logic [FW-1:0]             amount_ff, amount_in;
   logic [FW-1:0]             pos_ff, pos_in;
   logic [PW-1:0]             gap_start_ff, gap_start_in;
   logic [PW-1:0]             gap_stop_ff, gap_stop_in;
   logic [PW-1:0]             gap_len_ff, gap_len_in;
   logic [PW-1:0]             text_len_ff, text_len_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             moved_ff, moved_in;
   logic                      left_ff, left_in;
   logic                      full_ff, full_in;
   logic                      rd_bad_ff, rd_bad_in;
   logic [AW-1:0]             rd_addr_ff, rd_addr_in;
   logic                      wr_pend_ff, wr_pend_in;
   logic [AW-1:0]             wr_addr_ff, wr_addr_in;

   logic [gbts_pkg::STAT_W-1:0] status_ff, status_in;
   logic [FW-1:0]               cursor_ff, cursor_in;
   logic [FW-1:0]               tlen_ff, tlen_in;
   logic [FW-1:0]               omoved_ff, omoved_in;
   logic [BW-1:0]               rbyte_ff, rbyte_in;

   logic [CW-1:0] amt_ext, pos_ext, gs_ext, limit, rd_sum;
   logic [PW-1:0] room, text_len_now;
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [BW-1:0] ram_wdata, ram_rdata;

   assign amt_ext      = CW'(amount_ff);
   assign pos_ext      = CW'(pos_ff);
   assign gs_ext       = CW'(gap_start_ff);
   assign room         = PW'(CAPACITY) - gap_stop_ff;
   assign text_len_now = gap_start_ff + room;
   assign limit        = left_ff ? gs_ext : CW'(room);
   assign rd_sum       = pos_ext + CW'(gap_len_ff);

   assign stat.opcode     = op_ff;
   assign stat.count_zero = (count_ff == '0);

   always_comb begin
      op_in        = op_ff;
      byte_in      = byte_ff;
      amount_in    = amount_ff;
      pos_in       = pos_ff;
      gap_start_in = gap_start_ff;
      gap_stop_in  = gap_stop_ff;
      gap_len_in   = gap_len_ff;
      text_len_in  = text_len_ff;
      count_in     = count_ff;
      moved_in     = moved_ff;
      left_in      = left_ff;
      full_in      = full_ff;
      rd_bad_in    = rd_bad_ff;
      rd_addr_in   = rd_addr_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      status_in    = status_ff;
      cursor_in    = cursor_ff;
      tlen_in      = tlen_ff;
      omoved_in    = omoved_ff;
      rbyte_in     = rbyte_ff;
      ram_re       = 1'b0;
      ram_raddr    = rd_addr_ff;
      ram_we       = 1'b0;
      ram_waddr    = wr_addr_ff;
      ram_wdata    = ram_rdata;

      if (cmd.load) begin
         op_in     = req_opcode;
         byte_in   = req_data_byte;
         amount_in = req_amount;
         pos_in    = req_position;
      end

      if (cmd.prep) begin
         gap_len_in  = gap_stop_ff - gap_start_ff;
         text_len_in = text_len_now;
         count_in    = '0;
         left_in     = 1'b1;
         unique case (op_ff)
            gbts_pkg::OP_DELETE,
            gbts_pkg::OP_MOVE_LEFT: begin
               count_in = amt_ext;
            end
            gbts_pkg::OP_MOVE_RIGHT: begin
               count_in = amt_ext;
               left_in  = 1'b0;
            end
            gbts_pkg::OP_MOVE_TO: begin
               if (pos_ext <= gs_ext) begin
                  count_in = gs_ext - pos_ext;
               end else begin
                  count_in = pos_ext - gs_ext;
                  left_in  = 1'b0;
               end
            end
            default: begin
               count_in = '0;
            end
         endcase
      end

      if (cmd.clamp) begin
         count_in   = (count_ff > limit) ? limit : count_ff;
         moved_in   = count_in;
         full_in    = (gap_len_ff == '0);
         rd_bad_in  = (pos_ext >= CW'(text_len_ff));
         rd_addr_in = (pos_ext < gs_ext) ? pos_ext[AW-1:0] : rd_sum[AW-1:0];
      end

      // advance the gap by one byte; the write lands in the following cycle
      if (cmd.step) begin
         count_in   = count_ff - 1'b1;
         wr_pend_in = 1'b1;
         ram_re     = 1'b1;
         if (left_ff) begin
            ram_raddr    = AW'(gap_start_ff - 1'b1);
            wr_addr_in   = AW'(gap_stop_ff - 1'b1);
            gap_start_in = gap_start_ff - 1'b1;
            gap_stop_in  = gap_stop_ff - 1'b1;
         end else begin
            ram_raddr    = gap_stop_ff[AW-1:0];
            wr_addr_in   = gap_start_ff[AW-1:0];
            gap_start_in = gap_start_ff + 1'b1;
            gap_stop_in  = gap_stop_ff + 1'b1;
         end
      end

      if (wr_pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = wr_addr_ff;
         ram_wdata = ram_rdata;
      end

      if (cmd.exec) begin
         unique case (op_ff)
            gbts_pkg::OP_INSERT: begin
               if (!full_ff) begin
                  ram_we       = 1'b1;
                  ram_waddr    = gap_start_ff[AW-1:0];
                  ram_wdata    = byte_ff;
                  gap_start_in = gap_start_ff + 1'b1;
               end
            end
            gbts_pkg::OP_DELETE: begin
               gap_start_in = gap_start_ff - PW'(moved_ff);
            end
            gbts_pkg::OP_READ: begin
               ram_re    = 1'b1;
               ram_raddr = rd_addr_ff;
            end
            default: begin
               ram_re = 1'b0;
            end
         endcase
      end

      if (cmd.finish) begin
         status_in = gbts_pkg::ST_OK;
         rbyte_in  = '0;
         if ((op_ff == gbts_pkg::OP_INSERT) && full_ff) begin
            status_in = gbts_pkg::ST_FULL;
         end
         if (op_ff == gbts_pkg::OP_READ) begin
            if (rd_bad_ff) begin
               status_in = gbts_pkg::ST_RANGE;
            end else begin
               rbyte_in = ram_rdata;
            end
         end
         cursor_in = gs_ext[FW-1:0];
         tlen_in   = FW'(CW'(text_len_now));
         omoved_in = moved_ff[FW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_start_ff <= '0;
         gap_stop_ff  <= PW'(CAPACITY);
         wr_pend_ff   <= 1'b0;
         count_ff     <= '0;
      end else begin
         gap_start_ff <= gap_start_in;
         gap_stop_ff  <= gap_stop_in;
         wr_pend_ff   <= wr_pend_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      byte_ff     <= byte_in;
      amount_ff   <= amount_in;
      pos_ff      <= pos_in;
      gap_len_ff  <= gap_len_in;
      text_len_ff <= text_len_in;
      moved_ff    <= moved_in;
      left_ff     <= left_in;
      full_ff     <= full_in;
      rd_bad_ff   <= rd_bad_in;
      rd_addr_ff  <= rd_addr_in;
      wr_addr_ff  <= wr_addr_in;
      status_ff   <= status_in;
      cursor_ff   <= cursor_in;
      tlen_ff     <= tlen_in;
      omoved_ff   <= omoved_in;
      rbyte_ff    <= rbyte_in;
   end

   gbts_ram #(
      .WIDTH (BW),
      .DEPTH (CAPACITY)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_status      = status_ff;
   assign rsp_cursor      = cursor_ff;
   assign rsp_text_length = tlen_ff;
   assign rsp_moved       = omoved_ff;
   assign rsp_read_byte   = rbyte_ff;

endmodule

// ===== rtl/core/gap_buffer_text_store_core.sv =====
// Channel    Dir   Handshake      Word
// req_chan   in    valid/ready    opcode, data_byte, amount, position
// rsp_chan   out   valid/ready    status, cursor, text_length, moved, read_byte
//
// One operation at a time. Insert, delete, read and unused codes pass through the
// prep, clamp, exec and drain states; moves step through the clamped distance in
// place of exec, as the single text RAM copies one byte a cycle across the gap.
// Synchronous reset empties the store: cursor 0, gap covering the whole RAM.
// A result held in the output register does not block the next accept; the
// block stalls only when a new result is ready and the previous one is untaken.
module gap_buffer_text_store_core #(
   parameter int CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   gbts_req_if.sink    req_chan,
   gbts_rsp_if.source  rsp_chan
);

   gbts_pkg::dp_cmd_type  cmd;
   gbts_pkg::dp_stat_type stat;

   gbts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   gbts_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_chan.opcode),
      .req_data_byte   (req_chan.data_byte),
      .req_amount      (req_chan.amount),
      .req_position    (req_chan.position),
      .rsp_status      (rsp_chan.status),
      .rsp_cursor      (rsp_chan.cursor),
      .rsp_text_length (rsp_chan.text_length),
      .rsp_moved       (rsp_chan.moved),
      .rsp_read_byte   (rsp_chan.read_byte)
   );

endmodule
